/* rtl/dmf_pkg.sv */
// ============================================================================
// dmf_pkg
// Shared sizes, codes and bundles of the duplicate message filter.
// ============================================================================
package dmf_pkg;

    localparam int CACHE_DEPTH = 4096;                  // power of two, 2 .. 65536
    localparam int NCELL       = (CACHE_DEPTH >= 16) ? 16 : CACHE_DEPTH;
    localparam int SEG         = CACHE_DEPTH / NCELL;   // entries held by one cell
    localparam int SLOT_W      = $clog2(CACHE_DEPTH);
    localparam int CNT_W       = $clog2(CACHE_DEPTH + 1);
    localparam int AW          = (SEG > 1) ? $clog2(SEG) : 1;
    localparam int ID_W        = 64;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT     = 2'd0,
        VERDICT_INCOMPLETE = 2'd1,
        VERDICT_DUPLICATE  = 2'd2,
        VERDICT_NOT_MINE   = 2'd3
    } t_verdict;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0] sender;
        logic [ID_W-1:0] index;
    } t_key;

    // one lookup beat travelling down the row of cells
    typedef struct packed {
        logic          valid;
        logic          last;
        logic          hit;
        logic [AW-1:0] addr;
    } t_wave;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        t_key              key;
    } t_wr;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             full;
    } t_occ;

    // a slot holds a live pair once it has been filled at least once
    function automatic logic slot_live(input logic [SLOT_W-1:0] slot, input t_occ occ);
        return occ.full || (CNT_W'(slot) < occ.count);
    endfunction

endpackage

/* rtl/dmf_in_if.sv */
// ============================================================================
// dmf_in_if
// Request channel carrying one message routing header.
// ============================================================================
interface dmf_in_if;
    logic        valid;
    logic        ready;
    logic        header_complete;
    logic [63:0] origin_id;
    logic [63:0] msg_index;
    logic [63:0] receiver_id;

    modport source (
        output valid, header_complete, origin_id, msg_index, receiver_id,
        input  ready
    );
    modport sink (
        input  valid, header_complete, origin_id, msg_index, receiver_id,
        output ready
    );
endinterface

/* rtl/dmf_out_if.sv */
// ============================================================================
// dmf_out_if
// Result channel carrying the verdict for one message.
// ============================================================================
interface dmf_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;
    logic       deliver;
    logic       forward;

    modport source (
        output valid, verdict, deliver, forward,
        input  ready
    );
    modport sink (
        input  valid, verdict, deliver, forward,
        output ready
    );
endinterface

/* rtl/dmf_cfg_if.sv */
// ============================================================================
// dmf_cfg_if
// Configuration write channel for the node identifier.
// ============================================================================
interface dmf_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] own_node_id;

    modport source (
        output valid, own_node_id,
        input  ready
    );
    modport sink (
        input  valid, own_node_id,
        output ready
    );
endinterface

/* rtl/duplicate_message_filter.sv */
// Lookup: each request sends min(max(entries,1), SEG) beats into the cell row;
//   an incomplete header skips the lookup.
// One request at a time; the lookup sweeps each cell's slice memory one address per cycle,
//   then drains the cell row.
// A finished result waits in the output register while the next request is taken.
// Reset (sync, active low) empties the cache and clears own_node_id; no clearing pass.
// ============================================================================
// duplicate_message_filter
// FIFO duplicate suppression cache over a row of compare cells, with
// broadcast / local / forward classing of accepted messages.
// ============================================================================
module duplicate_message_filter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dmf_in_if.sink    i_req,
    dmf_out_if.source o_rsp,
    dmf_cfg_if.sink   i_cfg
);
    import dmf_pkg::*;

    t_wave w_chain [NCELL+1];
    t_key  w_key;
    t_wr   w_wr;
    t_occ  w_occ;

    dmf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cfg   (i_cfg),
        .o_wave  (w_chain[0]),
        .i_wave  (w_chain[NCELL]),
        .o_key   (w_key),
        .o_wr    (w_wr),
        .o_occ   (w_occ)
    );

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        dmf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_base  (SLOT_W'(g * SEG)),
            .i_occ   (w_occ),
            .i_key   (w_key),
            .i_wr    (w_wr),
            .i_wave  (w_chain[g]),
            .o_wave  (w_chain[g+1])
        );
    end

endmodule

/* rtl/dmf_cell.sv */
// ============================================================================
// dmf_cell
// One cache cell: a slice of the pair store, compared against the held key
// as lookup beats pass through, hit flag handed on to the next cell.
// ============================================================================
module dmf_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [dmf_pkg::SLOT_W-1:0] i_base,
    input  dmf_pkg::t_occ              i_occ,
    input  dmf_pkg::t_key              i_key,
    input  dmf_pkg::t_wr               i_wr,
    input  dmf_pkg::t_wave             i_wave,
    output dmf_pkg::t_wave             o_wave
);
    import dmf_pkg::*;

    t_key  r_mem [SEG];
    t_key  r_rd;
    t_wave r_wave_a;
    t_wave r_wave_b;
    t_wave n_wave_b;

    logic              w_wr_here;
    logic [AW-1:0]     w_wr_addr;
    logic [SLOT_W-1:0] w_slot;

    assign w_wr_here = i_wr.en && ((i_wr.slot / SEG) == (i_base / SEG));
    assign w_wr_addr = AW'(i_wr.slot % SEG);

    always_ff @(posedge i_clk) begin
        if (w_wr_here) begin
            r_mem[w_wr_addr] <= i_wr.key;
        end
        r_rd <= r_mem[i_wave.addr];
    end

    assign w_slot = i_base + SLOT_W'(r_wave_a.addr);

    always_comb begin
        n_wave_b     = r_wave_a;
        n_wave_b.hit = r_wave_a.hit
                     | (r_wave_a.valid && slot_live(w_slot, i_occ) && (r_rd == i_key));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_a.valid <= 1'b0;
            r_wave_b.valid <= 1'b0;
        end else begin
            r_wave_a <= i_wave;
            r_wave_b <= n_wave_b;
        end
    end

    assign o_wave = r_wave_b;

endmodule

/* rtl/dmf_ctrl.sv */
// ============================================================================
// dmf_ctrl
// Request sequencer: launches lookup beats into the cell row, collects the
// hit, classes the message, updates the FIFO cache and holds the result.
// ============================================================================
module dmf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dmf_in_if.sink         i_req,
    dmf_out_if.source      o_rsp,
    dmf_cfg_if.sink        i_cfg,
    output dmf_pkg::t_wave o_wave,
    input  dmf_pkg::t_wave i_wave,
    output dmf_pkg::t_key  o_key,
    output dmf_pkg::t_wr   o_wr,
    output dmf_pkg::t_occ  o_occ
);
    import dmf_pkg::*;

    t_state            r_state, n_state;
    t_key              r_key;
    logic              r_complete;
    logic [ID_W-1:0]   r_rcv;
    logic [ID_W-1:0]   r_own_id;
    logic              r_hit;
    logic [AW-1:0]     r_addr;
    logic [AW-1:0]     r_last_addr, n_last_addr;
    logic [CNT_W-1:0]  r_count;
    logic [SLOT_W-1:0] r_oldest;
    logic              r_out_valid;
    t_verdict          r_verdict, n_verdict;
    logic              r_deliver, n_deliver;
    logic              r_forward, n_forward;

    logic w_accept;
    logic w_finish;
    logic w_full;
    logic w_issue_last;

    assign w_accept     = i_req.valid && i_req.ready;
    assign w_full       = (r_count == CNT_W'(CACHE_DEPTH));
    assign w_issue_last = (r_addr == r_last_addr);

    // beats needed: min(count, SEG), at least one so a last marker always travels
    always_comb begin
        if (r_count >= CNT_W'(SEG)) begin
            n_last_addr = AW'(SEG - 1);
        end else if (r_count == '0) begin
            n_last_addr = '0;
        end else begin
            n_last_addr = AW'(r_count - CNT_W'(1));
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = i_req.header_complete ? ST_ISSUE : ST_FINISH;
                end
            end
            ST_ISSUE: begin
                if (w_issue_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_wave.valid && i_wave.last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_req.ready  = 1'b0;
        o_wave.valid = 1'b0;
        o_wave.last  = w_issue_last;
        o_wave.hit   = 1'b0;
        o_wave.addr  = r_addr;
        w_finish     = 1'b0;
        unique case (r_state)
            ST_IDLE:   i_req.ready  = 1'b1;
            ST_ISSUE:  o_wave.valid = 1'b1;
            ST_DRAIN:  ;
            ST_FINISH: w_finish     = !r_out_valid || o_rsp.ready;
            default:   ;
        endcase
    end

    assign o_key      = r_key;
    assign o_occ      = '{count: r_count, full: w_full};
    assign o_wr.en    = w_finish && r_complete && !r_hit;
    assign o_wr.slot  = r_oldest + SLOT_W'(r_count);   // wraps to oldest when full
    assign o_wr.key   = r_key;

    always_comb begin
        n_deliver = 1'b0;
        n_forward = 1'b0;
        if (!r_complete) begin
            n_verdict = VERDICT_INCOMPLETE;
        end else if (r_hit) begin
            n_verdict = VERDICT_DUPLICATE;
        end else if (r_rcv == '0) begin
            n_verdict = VERDICT_ACCEPT;
            n_deliver = 1'b1;
            n_forward = 1'b1;
        end else if (r_rcv == r_own_id) begin
            n_verdict = VERDICT_ACCEPT;
            n_deliver = 1'b1;
        end else begin
            n_verdict = VERDICT_NOT_MINE;
            n_forward = 1'b1;
        end
    end

    assign i_cfg.ready   = 1'b1;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.verdict = r_verdict;
    assign o_rsp.deliver = r_deliver;
    assign o_rsp.forward = r_forward;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_oldest    <= '0;
            r_own_id    <= '0;
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_own_id <= i_cfg.own_node_id;
            end
            if (w_accept) begin
                r_hit <= 1'b0;
            end else if (i_wave.valid && i_wave.hit) begin
                r_hit <= 1'b1;
            end
            if (o_wr.en) begin
                if (w_full) begin
                    r_oldest <= r_oldest + SLOT_W'(1);
                end else begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key.sender <= i_req.origin_id;
            r_key.index  <= i_req.msg_index;
            r_rcv        <= i_req.receiver_id;
            r_complete   <= i_req.header_complete;
            r_last_addr  <= n_last_addr;
            r_addr       <= '0;
        end else if (r_state == ST_ISSUE) begin
            r_addr <= r_addr + AW'(1);
        end
        if (w_finish) begin
            r_verdict <= n_verdict;
            r_deliver <= n_deliver;
            r_forward <= n_forward;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CACHE_DEPTH))
        else $error("cache fill count beyond depth");

    a_oldest_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_full |-> (r_oldest == '0))
        else $error("oldest slot moved before cache filled");

    a_beats_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wave.valid |-> (r_state == ST_ISSUE || r_state == ST_DRAIN))
        else $error("lookup beat outside a search");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_ISSUE || r_state == ST_FINISH))
        else $error("accepted request did not start");

endmodule

/* verif/duplicate_message_filter_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// duplicate_message_filter_tb
// Drives routing headers into the duplicate filter and checks every verdict
// against a predictor that mirrors the FIFO pair cache and node-id classing.
// ============================================================================
module duplicate_message_filter_tb;
    import dmf_pkg::*;

    localparam int unsigned RUN_LIMIT  = 12_000_000;
    localparam int unsigned END_PAUSE  = 400;
    localparam int unsigned FILL_COUNT = 600;
    localparam int unsigned KEY_MEMORY = 256;

    typedef bit [2*ID_W-1:0] t_pair_key;

    typedef struct {
        logic            complete;
        logic [ID_W-1:0] sender;
        logic [ID_W-1:0] index;
        logic [ID_W-1:0] receiver;
    } t_msg_hdr;

    typedef struct {
        t_verdict verdict;
        logic     deliver;
        logic     forward;
    } t_filter_result;

    logic i_clk;
    logic i_rst_n;

    dmf_in_if  req_if();
    dmf_out_if rsp_if();
    dmf_cfg_if cfg_if();

    duplicate_message_filter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // predictor state
    logic [ID_W-1:0] node_id;
    bit              cached_pairs[t_pair_key];
    t_pair_key       pair_age[$];
    t_filter_result  pending_verdicts[$];

    // stimulus state
    t_pair_key       offered_keys[$];
    logic [ID_W-1:0] talker_id[8];
    logic [ID_W-1:0] talker_seq[8];
    int unsigned     req_idle_pct;
    int unsigned     rsp_idle_pct;
    int unsigned     rsp_hold_left;

    // bookkeeping
    int unsigned headers_sent;
    int unsigned results_checked;
    int unsigned evictions;
    int unsigned mismatches;
    int unsigned verdict_count[4];
    int unsigned cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_verdicts.size());
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [ID_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // mirrors the filter: cache lookup, FIFO insert with eviction, classing
    function automatic t_filter_result predict_verdict(input t_msg_hdr h);
        t_filter_result r;
        t_pair_key      key;
        key = {h.sender, h.index};
        if (!h.complete) begin
            r = '{verdict: VERDICT_INCOMPLETE, deliver: 1'b0, forward: 1'b0};
        end else if (cached_pairs.exists(key)) begin
            r = '{verdict: VERDICT_DUPLICATE, deliver: 1'b0, forward: 1'b0};
        end else begin
            if (pair_age.size() == CACHE_DEPTH) begin
                cached_pairs.delete(pair_age.pop_front());
                evictions++;
            end
            pair_age.insert(pair_age.size(), key);
            cached_pairs[key] = 1'b1;
            if (h.receiver == '0)
                r = '{verdict: VERDICT_ACCEPT, deliver: 1'b1, forward: 1'b1};
            else if (h.receiver == node_id)
                r = '{verdict: VERDICT_ACCEPT, deliver: 1'b1, forward: 1'b0};
            else
                r = '{verdict: VERDICT_NOT_MINE, deliver: 1'b0, forward: 1'b1};
        end
        verdict_count[r.verdict]++;
        return r;
    endfunction

    // stop offering requests and wait until every verdict is back
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_verdicts.size() != 0);
    endtask

    task automatic write_node_id(input logic [ID_W-1:0] id);
        wait_drained();
        cfg_if.valid       <= 1'b1;
        cfg_if.own_node_id <= id;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        node_id = id;
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_header(input t_msg_hdr h);
        int unsigned gap;
        gap = 0;
        if ($urandom_range(99) < req_idle_pct)
            gap = ($urandom_range(7) == 0) ? $urandom_range(4, 300) : $urandom_range(1, 3);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid           <= 1'b1;
        req_if.header_complete <= h.complete;
        req_if.origin_id       <= h.sender;
        req_if.msg_index       <= h.index;
        req_if.receiver_id     <= h.receiver;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        pending_verdicts.insert(pending_verdicts.size(), predict_verdict(h));
        headers_sent++;
        if (h.complete) begin
            offered_keys.insert(offered_keys.size(), {h.sender, h.index});
            if (offered_keys.size() > KEY_MEMORY) void'(offered_keys.pop_front());
        end
    endtask

    task automatic send_fields(input logic c, input logic [ID_W-1:0] s,
                               input logic [ID_W-1:0] i, input logic [ID_W-1:0] r);
        t_msg_hdr h;
        h = '{complete: c, sender: s, index: i, receiver: r};
        send_header(h);
    endtask

    function automatic logic [ID_W-1:0] pick_receiver();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35) return '0;
        if (r < 65) return node_id;
        if (r < 75) return node_id ^ (64'd1 << $urandom_range(ID_W-1));
        return rand64();
    endfunction

    // sequenced traffic from a few talkers, with replays and noise
    function automatic t_msg_hdr random_header();
        t_msg_hdr    h;
        int unsigned r;
        int unsigned t;
        t_pair_key   k;
        r = $urandom_range(99);
        h.complete = ($urandom_range(99) >= 8);
        h.receiver = pick_receiver();
        if (r < 25 && offered_keys.size() != 0) begin
            k = offered_keys[$urandom_range(offered_keys.size() - 1)];
            h.sender = k[2*ID_W-1:ID_W];
            h.index  = k[ID_W-1:0];
        end else if (r < 70) begin
            t = $urandom_range(7);
            talker_seq[t] += $urandom_range(1, 2);
            h.sender = talker_id[t];
            h.index  = talker_seq[t];
        end else begin
            h.sender = rand64();
            h.index  = rand64();
        end
        return h;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // response side: random stalls, plus an explicit hold-off counter
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_hold_left > 0) begin
                rsp_hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_result
        t_filter_result want;
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got verdict %0d",
                         $time, rsp_if.verdict);
            end else begin
                want = pending_verdicts.pop_front();
                results_checked++;
                check_field("verdict", want.verdict, rsp_if.verdict);
                check_field("deliver", want.deliver, rsp_if.deliver);
                check_field("forward", want.forward, rsp_if.forward);
            end
        end
    end

    task automatic test_incomplete_headers();
        send_fields(1'b0, '1, '1, '1);
        send_fields(1'b0, '0, '0, '0);
    endtask

    // own id still zero from reset: zero receiver is broadcast
    task automatic test_classing_default_id();
        send_fields(1'b1, '0, '0, '0);
        send_fields(1'b1, '0, '0, '0);
        send_fields(1'b0, '0, '0, '0);    // cached pair but incomplete header
        send_fields(1'b1, '1, '1, '1);
        send_fields(1'b1, '1, '1, '0);    // same pair, other receiver
    endtask

    task automatic test_classing_with_node_id();
        logic [ID_W-1:0] id;
        write_node_id('1);
        send_fields(1'b1, 64'd1, '0, '1);
        send_fields(1'b1, '0, 64'd1, '0);
        send_fields(1'b1, 64'h8000_0000_0000_0000, '0, 64'h7FFF_FFFF_FFFF_FFFF);
        send_fields(1'b1, 64'd1, '0, '0);
        send_fields(1'b1, 64'd1, 64'd1, '1);
        id = rand64() | 64'd1;
        write_node_id(id);
        send_fields(1'b1, rand64(), rand64(), id);
        send_fields(1'b1, rand64(), rand64(), id ^ 64'd1);
        send_fields(1'b1, rand64(), rand64(), id ^ 64'h8000_0000_0000_0000);
        send_fields(1'b1, rand64(), rand64(), '0);
    endtask

    // receiver holds off long enough for the filter to stall its input
    task automatic test_backpressure();
        wait_drained();
        req_idle_pct  = 0;
        rsp_idle_pct  = 0;
        rsp_hold_left = 1500;
        repeat (8) send_header(random_header());
        wait_drained();
    endtask

    task automatic test_random_traffic(input int unsigned req_pct, input int unsigned rsp_pct,
                                       input int unsigned count, input logic [ID_W-1:0] id);
        write_node_id(id);
        req_idle_pct = req_pct;
        rsp_idle_pct = rsp_pct;
        repeat (count) send_header(random_header());
        wait_drained();
    endtask

    // grow the cache well past one cell slice so more than one cell holds live pairs
    task automatic test_cache_fill();
        logic [ID_W-1:0] base;
        t_msg_hdr        h;
        write_node_id(rand64());
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        base = rand64();
        for (int unsigned n = 0; n < FILL_COUNT; n++)
            send_fields(1'b1, base, ID_W'(n), pick_receiver());
        send_fields(1'b1, base, ID_W'(FILL_COUNT - 1), '0);   // newest, hit
        send_fields(1'b1, base, '0, '0);                      // oldest of the run, hit
        send_fields(1'b1, base, ID_W'(FILL_COUNT), '0);       // new pair
        send_fields(1'b1, base, ID_W'(FILL_COUNT), '0);       // just added, hit
        req_idle_pct = 13;
        rsp_idle_pct = 48;
        repeat (60) begin
            h = random_header();
            h.sender = base;
            h.index  = ID_W'($urandom_range(FILL_COUNT + 40));
            send_header(h);
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n                <= 1'b0;
        req_if.valid           <= 1'b0;
        req_if.header_complete <= 1'b0;
        req_if.origin_id       <= '0;
        req_if.msg_index       <= '0;
        req_if.receiver_id     <= '0;
        cfg_if.valid           <= 1'b0;
        cfg_if.own_node_id     <= '0;
        node_id         = '0;
        req_idle_pct    = 0;
        rsp_idle_pct    = 0;
        rsp_hold_left   = 0;
        headers_sent    = 0;
        results_checked = 0;
        evictions       = 0;
        mismatches      = 0;
        for (int k = 0; k < 4; k++) verdict_count[k] = 0;
        for (int k = 0; k < 8; k++) begin
            talker_id[k]  = rand64();
            talker_seq[k] = rand64();
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_incomplete_headers();
        test_classing_default_id();
        test_classing_with_node_id();
        test_backpressure();
        test_random_traffic(13, 48, 170, rand64());
        test_random_traffic(48, 13, 170, '1);
        test_random_traffic(0, 0, 170, '0);
        test_cache_fill();

        wait_drained();
        repeat (END_PAUSE) @(posedge i_clk);
        $display("Sent %0d headers: %0d accepted, %0d incomplete, %0d duplicate, %0d other node",
                 headers_sent, verdict_count[VERDICT_ACCEPT], verdict_count[VERDICT_INCOMPLETE],
                 verdict_count[VERDICT_DUPLICATE], verdict_count[VERDICT_NOT_MINE]);
        $display("Cache ended holding %0d pairs, %0d evictions; %0d results checked, %0d mismatches",
                 pair_age.size(), evictions, results_checked, mismatches);
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
